### hdl/assert_macros.svh
// assertion macros shared by the parser modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define AST_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define AST_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/astp_pkg.sv
// shared types, constants and character helpers for the modem stream parser
// no dependencies
package astp_pkg;

    localparam int MAX_LINKS_DEF     = 5;
    localparam int MAX_PAYLOAD_DEF   = 1024;
    localparam int LINE_CAPACITY_DEF = 63;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] PRINT_LO  = 8'h20;
    localparam logic [7:0] PRINT_HI  = 8'h7E;

    localparam logic [1:0] CS_INIT_FAIL = 2'd0;
    localparam logic [1:0] CS_AP_READY  = 2'd1;
    localparam logic [1:0] CS_CLIENT    = 2'd2;

    // classified input item
    typedef struct packed {
        logic [7:0] data;
        logic       busy;
        logic       is_digit;
        logic       is_print;
        logic       is_eol;
        logic [3:0] digit;
    } t_cls;

    // result item
    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  packet_link;
        logic        packet_end;
        logic [10:0] packet_length;
        logic [7:0]  link_mask;
        logic [2:0]  active_link;
        logic [3:0]  client_count;
        logic [1:0]  connection_state;
    } t_res;

    // ",CONNECT" by position
    function automatic logic [7:0] sfx_conn(input logic [2:0] k);
        logic [7:0] ch;
        case (k)
            3'd0:    ch = 8'h2C;
            3'd1:    ch = 8'h43;
            3'd2:    ch = 8'h4F;
            3'd3:    ch = 8'h4E;
            3'd4:    ch = 8'h4E;
            3'd5:    ch = 8'h45;
            3'd6:    ch = 8'h43;
            default: ch = 8'h54;
        endcase
        return ch;
    endfunction

    // ",CLOSED" by position
    function automatic logic [7:0] sfx_clos(input logic [2:0] k);
        logic [7:0] ch;
        case (k)
            3'd0:    ch = 8'h2C;
            3'd1:    ch = 8'h43;
            3'd2:    ch = 8'h4C;
            3'd3:    ch = 8'h4F;
            3'd4:    ch = 8'h53;
            3'd5:    ch = 8'h45;
            default: ch = 8'h44;
        endcase
        return ch;
    endfunction

    // "IPD," by position
    function automatic logic [7:0] hdr_char(input logic [1:0] k);
        logic [7:0] ch;
        case (k)
            2'd0:    ch = 8'h49;
            2'd1:    ch = 8'h50;
            2'd2:    ch = 8'h44;
            default: ch = 8'h2C;
        endcase
        return ch;
    endfunction

endpackage

### hdl/at_stream_link_and_payload_parser_top.sv
// Modem receive-stream parser, top level.
// Input channel: i_push / o_full carry one received byte (i_rx_byte) and its
// host-busy flag; an item is taken when i_push is high and o_full low.
// Result channel: o_empty / i_pop; while o_empty is low the oldest result is
// on the o_ ports, and it leaves on an edge with i_pop high.
// Every input item gives exactly one result: payload flag, byte, link and
// length of the current packet, end-of-packet mark, and the link status.
// Configuration: i_cfg_we writes i_cfg_wdata into init_done on that edge.
// Results: a taken item waits in the input queue, is parsed when the result
// queue has room, and its result is registered into the result queue.
// Throughput: one item per cycle while the result queue has room, set by the
// combinational parser step between the input queue and the result queue.
// When the receiver holds off i_pop the result queue fills, the parser
// stalls, then the input queue fills and o_full rises; nothing is lost.
// Reset (synchronous, i_rst_n low) empties both queues, clears the link
// table and init_done, and returns both parsers to their idle state.
// depends on astp_pkg, astp_front, astp_back
module at_stream_link_and_payload_parser_top #(
    parameter int MAX_LINKS     = astp_pkg::MAX_LINKS_DEF,
    parameter int MAX_PAYLOAD   = astp_pkg::MAX_PAYLOAD_DEF,
    parameter int LINE_CAPACITY = astp_pkg::LINE_CAPACITY_DEF,
    parameter int QUEUE_DEPTH   = astp_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_host_busy,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_payload_valid,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_packet_link,
    output logic        o_packet_end,
    output logic [10:0] o_packet_length,
    output logic [7:0]  o_link_mask,
    output logic [2:0]  o_active_link,
    output logic [3:0]  o_client_count,
    output logic [1:0]  o_connection_state
);
    import astp_pkg::*;

    t_cls item;
    t_res res;
    logic item_empty, item_pop;

    astp_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_rx_byte   (i_rx_byte),
        .i_host_busy (i_host_busy),
        .i_pop       (item_pop),
        .o_item      (item),
        .o_empty     (item_empty)
    );

    astp_back #(
        .MAX_LINKS     (MAX_LINKS),
        .MAX_PAYLOAD   (MAX_PAYLOAD),
        .LINE_CAPACITY (LINE_CAPACITY),
        .DEPTH         (QUEUE_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item       (item),
        .i_item_empty (item_empty),
        .o_item_pop   (item_pop),
        .i_pop        (i_pop),
        .o_res        (res),
        .o_empty      (o_empty)
    );

    assign o_payload_valid    = res.payload_valid;
    assign o_payload_byte     = res.payload_byte;
    assign o_packet_link      = res.packet_link;
    assign o_packet_end       = res.packet_end;
    assign o_packet_length    = res.packet_length;
    assign o_link_mask        = res.link_mask;
    assign o_active_link      = res.active_link;
    assign o_client_count     = res.client_count;
    assign o_connection_state = res.connection_state;

endmodule

### hdl/astp_fifo.sv
// small register queue with full and empty flags decoded from a registered count
// depends on assert_macros.svh
`include "assert_macros.svh"
module astp_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `AST_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "queue count over depth")
    `AST_NEXT(a_count_up, i_clk, i_rst_n, do_push && !do_pop, r_count == $past(r_count) + 1'b1, "queue count did not grow on push")

endmodule

### hdl/astp_front.sv
// front end: classifies each received byte and queues it for the parser
// depends on astp_pkg and astp_fifo
module astp_front #(
    parameter int DEPTH = astp_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_host_busy,
    input  logic            i_pop,
    output astp_pkg::t_cls  o_item,
    output logic            o_empty
);
    import astp_pkg::*;

    t_cls cls;

    always_comb begin
        cls.data     = i_rx_byte;
        cls.busy     = i_host_busy;
        cls.is_digit = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
        cls.is_eol   = (i_rx_byte == CH_CR) || (i_rx_byte == CH_LF);
        cls.is_print = (i_rx_byte >= PRINT_LO) && (i_rx_byte <= PRINT_HI);
        cls.digit    = i_rx_byte[3:0];
    end

    astp_fifo #(.W($bits(t_cls)), .DEPTH(DEPTH)) u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cls),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (o_item),
        .o_empty (o_empty)
    );

endmodule

### hdl/astp_back.sv
// back end: line recognizer, packet framer and result queue
// depends on astp_pkg, astp_fifo and assert_macros.svh
`include "assert_macros.svh"
module astp_back #(
    parameter int MAX_LINKS     = astp_pkg::MAX_LINKS_DEF,
    parameter int MAX_PAYLOAD   = astp_pkg::MAX_PAYLOAD_DEF,
    parameter int LINE_CAPACITY = astp_pkg::LINE_CAPACITY_DEF,
    parameter int DEPTH         = astp_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    input  astp_pkg::t_cls  i_item,
    input  logic            i_item_empty,
    output logic            o_item_pop,
    input  logic            i_pop,
    output astp_pkg::t_res  o_res,
    output logic            o_empty
);
    import astp_pkg::*;

    localparam int LLW = $clog2(LINE_CAPACITY + 1);

    localparam logic [5:0] LM_START     = 6'd0;
    localparam logic [5:0] LM_DIGITS    = 6'd1;
    localparam logic [5:0] LM_FAIL      = 6'd2;
    localparam logic [5:0] LM_CONN      = 6'd16;
    localparam logic [5:0] LM_CONN_DONE = 6'd24;
    localparam logic [5:0] LM_CLOS      = 6'd32;
    localparam logic [5:0] LM_CLOS_DONE = 6'd39;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_PLUS = 5'b00010,
        PH_LINK = 5'b00100,
        PH_LEN  = 5'b01000,
        PH_DATA = 5'b10000
    } t_phase;

    t_phase      r_ph, n_ph;
    logic [1:0]  r_hcnt, n_hcnt;
    logic        r_hok, n_hok;
    logic [7:0]  r_flink, n_flink;
    logic [15:0] r_flen, n_flen;
    logic [15:0] r_fcnt, n_fcnt;
    logic [LLW-1:0] r_llen, n_llen;
    logic [15:0] r_lnum, n_lnum;
    logic [5:0]  r_lm, n_lm;
    logic [7:0]  r_mask, n_mask;
    logic [2:0]  r_cur, n_cur;
    logic [3:0]  r_count, n_count;
    logic        r_init_done;

    logic        take, out_full, valid, endp;
    logic [7:0]  id;
    logic [2:0]  low;
    logic [7:0]  c;
    t_res        res;

    assign c          = i_item.data;
    assign take       = !i_item_empty && !out_full;
    assign o_item_pop = take;

    always_comb begin
        n_ph    = r_ph;
        n_hcnt  = r_hcnt;
        n_hok   = r_hok;
        n_flink = r_flink;
        n_flen  = r_flen;
        n_fcnt  = r_fcnt;
        n_llen  = r_llen;
        n_lnum  = r_lnum;
        n_lm    = r_lm;
        n_mask  = r_mask;
        n_cur   = r_cur;
        n_count = r_count;
        valid   = 1'b0;
        endp    = 1'b0;
        id      = r_lnum[7:0];
        low     = '0;
        if (!i_item.busy) begin
            // line recognizer
            if (i_item.is_eol) begin
                if (r_llen != '0) begin
                    if (r_lm == LM_CONN_DONE && id < 8'(MAX_LINKS)) begin
                        if (!r_mask[id[2:0]]) begin
                            n_mask[id[2:0]] = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                        n_cur = id[2:0];
                    end else if (r_lm == LM_CLOS_DONE && id < 8'(MAX_LINKS)) begin
                        if (r_mask[id[2:0]]) begin
                            n_mask[id[2:0]] = 1'b0;
                            if (r_count != '0) begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        for (int i = MAX_LINKS - 1; i >= 0; i--) begin
                            if (n_mask[i]) begin
                                low = 3'(i);
                            end
                        end
                        if (!n_mask[r_cur]) begin
                            n_cur = low;
                        end
                    end
                    n_llen = '0;
                    n_lnum = '0;
                    n_lm   = LM_START;
                end
            end else if (i_item.is_print && r_llen < LLW'(LINE_CAPACITY)) begin
                n_llen = r_llen + 1'b1;
                if (r_lm == LM_START) begin
                    if (i_item.is_digit) begin
                        n_lnum = {12'd0, i_item.digit};
                        n_lm   = LM_DIGITS;
                    end else begin
                        n_lm = LM_FAIL;
                    end
                end else if (r_lm == LM_DIGITS) begin
                    if (i_item.is_digit) begin
                        n_lnum = (r_lnum << 3) + (r_lnum << 1) + {12'd0, i_item.digit};
                    end else if (c == CH_COMMA) begin
                        n_lm = LM_CONN + 6'd1;
                    end else begin
                        n_lm = LM_FAIL;
                    end
                end else if (r_lm > LM_CONN && r_lm < LM_CONN_DONE) begin
                    if (c == sfx_conn(r_lm[2:0])) begin
                        n_lm = r_lm + 6'd1;
                    end else if (r_lm[2:0] == 3'd2 && c == CH_L) begin
                        // ",CL" switches to the close suffix
                        n_lm = LM_CLOS + 6'd3;
                    end else begin
                        n_lm = LM_FAIL;
                    end
                end else if (r_lm > LM_CLOS && r_lm < LM_CLOS_DONE) begin
                    n_lm = (c == sfx_clos(r_lm[2:0])) ? r_lm + 6'd1 : LM_FAIL;
                end else begin
                    n_lm = LM_FAIL;
                end
            end

            // packet framer
            case (r_ph)
                PH_IDLE: begin
                    if (c == CH_PLUS) begin
                        n_ph   = PH_PLUS;
                        n_hcnt = '0;
                        n_hok  = 1'b1;
                    end
                end
                PH_PLUS: begin
                    n_hok  = r_hok && (c == hdr_char(r_hcnt));
                    n_hcnt = r_hcnt + 1'b1;
                    if (r_hcnt == 2'd3) begin
                        if (n_hok) begin
                            n_ph    = PH_LINK;
                            n_flink = '0;
                        end else begin
                            n_ph = PH_IDLE;
                        end
                    end
                end
                PH_LINK: begin
                    if (c == CH_COMMA) begin
                        n_ph   = PH_LEN;
                        n_flen = '0;
                    end else if (i_item.is_digit) begin
                        n_flink = (r_flink << 3) + (r_flink << 1) + {4'd0, i_item.digit};
                    end else begin
                        n_ph = PH_IDLE;
                    end
                end
                PH_LEN: begin
                    if (c == CH_COLON) begin
                        n_ph   = PH_DATA;
                        n_fcnt = '0;
                        if (r_flen > 16'(MAX_PAYLOAD)) begin
                            n_flen = 16'(MAX_PAYLOAD);
                        end
                    end else if (i_item.is_digit) begin
                        n_flen = (r_flen << 3) + (r_flen << 1) + {12'd0, i_item.digit};
                    end else begin
                        n_ph = PH_IDLE;
                    end
                end
                PH_DATA: begin
                    if (r_fcnt < r_flen) begin
                        valid  = 1'b1;
                        n_fcnt = r_fcnt + 1'b1;
                    end
                    if (n_fcnt >= r_flen) begin
                        endp = 1'b1;
                        n_ph = PH_IDLE;
                    end
                end
                default: n_ph = PH_IDLE;
            endcase
        end

        res.payload_valid    = valid;
        res.payload_byte     = valid ? c : 8'd0;
        res.packet_link      = (valid || endp) ? n_flink : 8'd0;
        res.packet_end       = endp;
        res.packet_length    = (valid || endp) ? n_flen[10:0] : 11'd0;
        res.link_mask        = n_mask;
        res.active_link      = n_cur;
        res.client_count     = n_count;
        res.connection_state = !r_init_done ? CS_INIT_FAIL :
                               (n_count != '0) ? CS_CLIENT : CS_AP_READY;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph        <= PH_IDLE;
            r_hcnt      <= '0;
            r_hok       <= 1'b0;
            r_flink     <= '0;
            r_flen      <= '0;
            r_fcnt      <= '0;
            r_llen      <= '0;
            r_lnum      <= '0;
            r_lm        <= LM_START;
            r_mask      <= '0;
            r_cur       <= '0;
            r_count     <= '0;
            r_init_done <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_init_done <= i_cfg_wdata;
            end
            if (take) begin
                r_ph    <= n_ph;
                r_hcnt  <= n_hcnt;
                r_hok   <= n_hok;
                r_flink <= n_flink;
                r_flen  <= n_flen;
                r_fcnt  <= n_fcnt;
                r_llen  <= n_llen;
                r_lnum  <= n_lnum;
                r_lm    <= n_lm;
                r_mask  <= n_mask;
                r_cur   <= n_cur;
                r_count <= n_count;
            end
        end
    end

    astp_fifo #(.W($bits(t_res)), .DEPTH(DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_data  (res),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  (o_res),
        .o_empty (o_empty)
    );

    `AST_ALWAYS(a_count_matches_mask, i_clk, i_rst_n, $countones(r_mask) == 32'(r_count), "client count differs from link mask")
    `AST_IMPLY(a_payload_has_length, i_clk, i_rst_n, take && res.payload_valid, res.packet_length != 11'd0, "payload byte with zero length")

endmodule

### tb/tb_at_stream_link_and_payload_parser_top.sv
// testbench for at_stream_link_and_payload_parser_top: queue-style handshakes on both sides,
// a local predictor of link events and packet framing, per-field result checks
// depends on astp_pkg and the parser rtl
`timescale 1ns / 1ps

module tb_at_stream_link_and_payload_parser_top;
    import astp_pkg::*;

    localparam int N_LINKS   = 5;
    localparam int PAY_MAX   = 1024;
    localparam int LINE_CAP  = 63;
    localparam int LM_START  = 0;
    localparam int LM_DIGITS = 1;
    localparam int LM_FAIL   = 2;
    localparam int LM_CONN   = 16;
    localparam int LM_CLOS   = 32;
    localparam int PH_IDLE   = 0;
    localparam int PH_PLUS   = 1;
    localparam int PH_LINK   = 2;
    localparam int PH_LEN    = 3;
    localparam int PH_DATA   = 4;
    localparam string CONN_SFX = ",CONNECT";
    localparam string CLOS_SFX = ",CLOSED";

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_push = 1'b0;
    logic        o_full;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_host_busy = 1'b0;
    logic        o_empty;
    logic        i_pop = 1'b0;
    logic        o_payload_valid;
    logic [7:0]  o_payload_byte;
    logic [7:0]  o_packet_link;
    logic        o_packet_end;
    logic [10:0] o_packet_length;
    logic [7:0]  o_link_mask;
    logic [2:0]  o_active_link;
    logic [3:0]  o_client_count;
    logic [1:0]  o_connection_state;

    at_stream_link_and_payload_parser_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_push(i_push), .o_full(o_full),
        .i_rx_byte(i_rx_byte), .i_host_busy(i_host_busy),
        .o_empty(o_empty), .i_pop(i_pop),
        .o_payload_valid(o_payload_valid), .o_payload_byte(o_payload_byte),
        .o_packet_link(o_packet_link), .o_packet_end(o_packet_end),
        .o_packet_length(o_packet_length), .o_link_mask(o_link_mask),
        .o_active_link(o_active_link), .o_client_count(o_client_count),
        .o_connection_state(o_connection_state)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    int          phase;
    logic [7:0]  hdr [4];
    int          hdr_cnt;
    logic [7:0]  pkt_link;
    logic [15:0] pkt_len;
    logic [15:0] pkt_cnt;
    int          ln_len;
    logic [15:0] ln_num;
    int          ln_state;
    logic [7:0]  mask;
    logic [2:0]  act;
    logic [3:0]  nconn;
    logic        init_done;

    t_res expected_q[$];
    int   errors = 0;
    int   n_items = 0;

    function automatic bit is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void pick_lowest_link();
        act = 3'd0;
        for (int i = N_LINKS - 1; i >= 0; i--) begin
            if (mask[i]) act = i[2:0];
        end
    endfunction

    function automatic void line_step(logic [7:0] c);
        logic [7:0] id;
        int k;
        if (c == CH_CR || c == CH_LF) begin
            if (ln_len > 0) begin
                id = ln_num[7:0];
                if (ln_state == LM_CONN + 8 && id < N_LINKS) begin
                    if (!mask[id]) begin
                        mask[id] = 1'b1;
                        nconn = nconn + 4'd1;
                    end
                    act = id[2:0];
                end else if (ln_state == LM_CLOS + 7 && id < N_LINKS) begin
                    if (mask[id]) begin
                        mask[id] = 1'b0;
                        if (nconn > 0) nconn = nconn - 4'd1;
                    end
                    if (!mask[act]) pick_lowest_link();
                end
                ln_len = 0;
                ln_num = 16'd0;
                ln_state = LM_START;
            end
            return;
        end
        if (c < PRINT_LO || c > PRINT_HI || ln_len >= LINE_CAP) return;
        ln_len++;
        if (ln_state == LM_START) begin
            if (is_dig(c)) begin
                ln_num = c - "0";
                ln_state = LM_DIGITS;
            end else ln_state = LM_FAIL;
        end else if (ln_state == LM_DIGITS) begin
            if (is_dig(c)) ln_num = ln_num * 16'd10 + (c - "0");
            else if (c == ",") ln_state = LM_CONN + 1;
            else ln_state = LM_FAIL;
        end else if (ln_state > LM_CONN && ln_state < LM_CONN + 8) begin
            k = ln_state - LM_CONN;
            if (c == CONN_SFX[k]) ln_state++;
            else if (k == 2 && c == "L") ln_state = LM_CLOS + 3;
            else ln_state = LM_FAIL;
        end else if (ln_state > LM_CLOS && ln_state < LM_CLOS + 7) begin
            k = ln_state - LM_CLOS;
            ln_state = (c == CLOS_SFX[k]) ? ln_state + 1 : LM_FAIL;
        end else ln_state = LM_FAIL;
    endfunction

    function automatic t_res parse_byte(logic [7:0] c, logic busy);
        t_res r;
        logic v, e;
        v = 1'b0;
        e = 1'b0;
        r = '0;
        if (!busy) begin
            line_step(c);
            case (phase)
                PH_IDLE: begin
                    if (c == "+") begin
                        phase = PH_PLUS;
                        hdr_cnt = 0;
                    end
                end
                PH_PLUS: begin
                    hdr[hdr_cnt] = c;
                    hdr_cnt++;
                    if (hdr_cnt >= 4) begin
                        if (hdr[0] == "I" && hdr[1] == "P" && hdr[2] == "D" && hdr[3] == ",") begin
                            phase = PH_LINK;
                            pkt_link = 8'd0;
                        end else phase = PH_IDLE;
                    end
                end
                PH_LINK: begin
                    if (c == ",") begin
                        phase = PH_LEN;
                        pkt_len = 16'd0;
                    end else if (is_dig(c)) pkt_link = pkt_link * 8'd10 + (c - "0");
                    else phase = PH_IDLE;
                end
                PH_LEN: begin
                    if (c == ":") begin
                        phase = PH_DATA;
                        pkt_cnt = 16'd0;
                        if (pkt_len > PAY_MAX) pkt_len = PAY_MAX;
                    end else if (is_dig(c)) pkt_len = pkt_len * 16'd10 + (c - "0");
                    else phase = PH_IDLE;
                end
                PH_DATA: begin
                    if (pkt_cnt < pkt_len) begin
                        v = 1'b1;
                        r.payload_byte = c;
                        pkt_cnt++;
                    end
                    if (pkt_cnt >= pkt_len) begin
                        e = 1'b1;
                        phase = PH_IDLE;
                    end
                end
                default: phase = PH_IDLE;
            endcase
        end
        r.payload_valid = v;
        r.packet_end = e;
        if (v || e) begin
            r.packet_link = pkt_link;
            r.packet_length = pkt_len[10:0];
        end
        r.link_mask = mask;
        r.active_link = act;
        r.client_count = nconn;
        r.connection_state = !init_done ? CS_INIT_FAIL : (nconn > 0 ? CS_CLIENT : CS_AP_READY);
        return r;
    endfunction

    task automatic send_byte(logic [7:0] c, logic busy);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_rx_byte <= c;
        i_host_busy <= busy;
        do @(posedge i_clk); while (o_full);
        expected_q.push_back(parse_byte(c, busy));
        n_items++;
    endtask

    // busy_pct: chance in percent that a byte is sent with the host busy
    task automatic send_str(string s, int busy_pct = 0);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], $urandom_range(0, 99) < busy_pct);
    endtask

    task automatic send_packet(int link, int len, int nbytes, int busy_pct = 0);
        send_str($sformatf("+IPD,%0d,%0d:", link, len), busy_pct);
        for (int i = 0; i < nbytes; i++)
            send_byte($urandom_range(0, 255), $urandom_range(0, 99) < busy_pct);
    endtask

    task automatic write_init_done(logic v);
        i_push <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        init_done = v;
    endtask

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // result side: random pop stalls, compare each popped item with the oldest prediction
    initial begin
        t_res e;
        int stall;
        forever begin
            stall = $urandom_range(0, 5);
            if (stall > 0) begin
                i_pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_pop <= 1'b1;
            do @(posedge i_clk); while (o_empty || !i_rst_n);
            if (expected_q.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
            end else begin
                e = expected_q.pop_front();
                check_field("payload_valid", e.payload_valid, o_payload_valid);
                check_field("payload_byte", e.payload_byte, o_payload_byte);
                check_field("packet_link", e.packet_link, o_packet_link);
                check_field("packet_end", e.packet_end, o_packet_end);
                check_field("packet_length", e.packet_length, o_packet_length);
                check_field("link_mask", e.link_mask, o_link_mask);
                check_field("active_link", e.active_link, o_active_link);
                check_field("client_count", e.client_count, o_client_count);
                check_field("connection_state", e.connection_state, o_connection_state);
            end
        end
    end

    task automatic test_status_after_reset();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_link_events();
        send_str("3,CONNECT\r");
        send_str("0,CONNECT\n");
        send_str("3,CLOSED\r");
        send_str("4,CONNECT\r\n");
        send_str("0,CLOSED\n");
        send_str("2,CLOSED\n");
        send_str("261,CONNECT\r");
        send_str("65540,CLOSED\r");
        send_str("9,CONNECT\r");
        send_str("4,CONNEC\r");
    endtask

    task automatic test_packets();
        send_packet(1, 3, 3);
        send_packet(0, 0, 1);
        send_packet(300, 65537, 1);
        send_packet(2, 1030, 1024);
        send_str("+IPX,1,2:ab+IPD,x");
        send_str("+IPD,2,5:", 0);
        send_byte("a", 1'b1);
        send_packet(4, 2, 0);
        send_str("zz");
    endtask

    task automatic test_line_corners();
        string s;
        s = "1";
        for (int i = 0; i < 62; i++) s = {s, "0"};
        send_str({s, ",CONNECT\r"});
        send_str("\r\n2,\tCONN\x01ECT\n");
        send_str("1,CONNECT\r", 30);
        send_str("1,CLOSED\r");
    endtask

    task automatic test_random_stream();
        int kind;
        int len;
        while (n_items < 1300) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1: send_str($sformatf("%0d,CONNECT%s", $urandom_range(0, 7),
                                         $urandom_range(0, 1) ? "\r" : "\n"), 3);
                2, 3: send_str($sformatf("%0d,CLOSED%s", $urandom_range(0, 7),
                                         $urandom_range(0, 1) ? "\r\n" : "\n"), 3);
                4, 5, 6: begin
                    len = $urandom_range(0, 12);
                    send_packet($urandom_range(0, 300), len, len + $urandom_range(0, 1), 3);
                end
                7: send_str($urandom_range(0, 1) ? "+IP" : "1,CLO\r");
                default: begin
                    repeat ($urandom_range(1, 6))
                        send_byte($urandom_range(0, 255), $urandom_range(0, 9) == 0);
                end
            endcase
        end
    endtask

    initial begin
        phase = PH_IDLE;
        hdr_cnt = 0;
        pkt_link = 8'd0;
        pkt_len = 16'd0;
        pkt_cnt = 16'd0;
        ln_len = 0;
        ln_num = 16'd0;
        ln_state = LM_START;
        mask = 8'd0;
        act = 3'd0;
        nconn = 4'd0;
        init_done = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_status_after_reset();
        test_link_events();
        write_init_done(1'b1);
        test_status_after_reset();
        test_link_events();
        test_packets();
        write_init_done(1'b0);
        test_line_corners();
        write_init_done(1'b1);
        test_random_stream();
        i_push <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("[at_stream_link_and_payload_parser_top] OK");
        end else begin
            $display("[at_stream_link_and_payload_parser_top] ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("[at_stream_link_and_payload_parser_top] ERROR");
        $finish;
    end

endmodule
